>>> rtl/core/wbig_pkg.sv
// Shared types and constants of the window border/interior GLRT detector.
// Holds field widths, register codes, reset values and the control structs.
// No dependencies; the other files, wbig_div apart, refer to it by scoped names.
`timescale 1ns / 1ps

package wbig_pkg;

    localparam int PIXEL_W    = 8;
    localparam int DIM_W      = 6;
    localparam int RECIP_W    = 17;
    localparam int SCORE_W    = 35;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    // Register indexes, byte address = 4 * index.
    localparam logic [1:0] REG_WINDOW_HEIGHT           = 2'd0;
    localparam logic [1:0] REG_WINDOW_WIDTH            = 2'd1;
    localparam logic [1:0] REG_BORDER_VARIANCE_RECIP   = 2'd2;
    localparam logic [1:0] REG_INTERIOR_VARIANCE_RECIP = 2'd3;

    localparam logic [DIM_W-1:0]   RST_WINDOW_HEIGHT = 6'd8;
    localparam logic [DIM_W-1:0]   RST_WINDOW_WIDTH  = 6'd8;
    localparam logic [RECIP_W-1:0] RST_RECIP         = 17'd65536;

    // The ring of a rectangle counts each corner once.
    localparam int RING_CORNERS = 4;

    localparam logic signed [SCORE_W-1:0] SCORE_MAX = 35'sh3_FFFF_FFFF;
    localparam logic signed [SCORE_W-1:0] SCORE_MIN = 35'sh4_0000_0000;

    typedef logic [1:0] t_group;
    localparam t_group GRP_BORDER   = 2'd0;
    localparam t_group GRP_INTERIOR = 2'd1;
    localparam t_group GRP_WHOLE    = 2'd2;

    typedef struct packed {
        logic   acc_en;
        t_group grp;
        logic   load_ops;
        logic   mul_ops;
        logic   div_start;
        logic   store_zero;
        logic   store_quot;
        logic   score_mul;
        logic   load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic last_pixel;
        logic not_positive;
        logic div_done;
        logic out_free;
    } t_dp_stat;

endpackage

>>> rtl/core/wbig_ctrl.sv
// Sequencer of the detector: accepts pixels and steps the end-of-window finish.
// Depends on wbig_pkg for the command and status structs and the group codes.
`timescale 1ns / 1ps

module wbig_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  wbig_pkg::t_dp_stat i_stat,
    output wbig_pkg::t_dp_cmd  o_cmd
);

    localparam logic [2:0] S_ACC       = 3'd0;
    localparam logic [2:0] S_LOAD      = 3'd1;
    localparam logic [2:0] S_MUL       = 3'd2;
    localparam logic [2:0] S_CHECK     = 3'd3;
    localparam logic [2:0] S_DIV       = 3'd4;
    localparam logic [2:0] S_SCORE_MUL = 3'd5;
    localparam logic [2:0] S_OUT       = 3'd6;

    logic [2:0]       r_state, n_state;
    wbig_pkg::t_group r_grp, n_grp;
    logic             group_done;

    assign o_ready = (r_state == S_ACC);

    always_comb begin
        n_state    = r_state;
        n_grp      = r_grp;
        group_done = 1'b0;
        o_cmd      = '0;
        o_cmd.grp  = r_grp;
        case (r_state)
            S_ACC: begin
                o_cmd.acc_en = i_valid;
                if (i_valid && i_stat.last_pixel) begin
                    n_state = S_LOAD;
                    n_grp   = wbig_pkg::GRP_BORDER;
                end
            end
            S_LOAD: begin
                o_cmd.load_ops = 1'b1;
                n_state        = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_ops = 1'b1;
                n_state       = S_CHECK;
            end
            S_CHECK: begin
                if (i_stat.not_positive) begin
                    o_cmd.store_zero = 1'b1;
                    group_done       = 1'b1;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.store_quot = 1'b1;
                    group_done       = 1'b1;
                end
            end
            S_SCORE_MUL: begin
                o_cmd.score_mul = 1'b1;
                n_state         = S_OUT;
            end
            S_OUT: begin
                // Hold the finished score until the output register is free.
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_ACC;
                end
            end
            default: begin
                n_state = S_ACC;
            end
        endcase
        if (group_done) begin
            if (r_grp == wbig_pkg::GRP_WHOLE) begin
                n_state = S_SCORE_MUL;
            end else begin
                n_grp   = r_grp + 2'd1;
                n_state = S_LOAD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACC;
            r_grp   <= wbig_pkg::GRP_BORDER;
        end else begin
            r_state <= n_state;
            r_grp   <= n_grp;
        end
    end

endmodule

>>> rtl/core/wbig_div.sv
// Restoring divider, one quotient bit per cycle, for the scatter terms.
// No dependencies on the package; widths come from its parameters.
`timescale 1ns / 1ps

module wbig_div #(
    parameter int NW = 45,
    parameter int DW = 11
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_done,
    output logic [NW-1:0] o_quotient
);

    localparam int CNTW = $clog2(NW + 1);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [DW-1:0]   r_rem;
    logic [NW-1:0]   r_quot;
    logic [DW:0]     shifted;
    logic            fits;

    assign shifted    = {r_rem, r_quot[NW-1]};
    assign fits       = (shifted >= {1'b0, i_divisor});
    assign o_done     = r_done;
    assign o_quotient = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_dividend;
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= DW'(shifted - {1'b0, i_divisor});
            end else begin
                r_rem <= shifted[DW-1:0];
            end
            r_quot <= {r_quot[NW-2:0], fits};
        end
    end

endmodule

>>> rtl/core/wbig_dp.sv
// Datapath of the detector: position counters, group sums, scatter terms,
// score arithmetic and output register. Depends on wbig_pkg and wbig_div.
`timescale 1ns / 1ps

module wbig_dp #(
    parameter int MAX_WINDOW_SIDE = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  wbig_pkg::t_dp_cmd                    i_cmd,
    output wbig_pkg::t_dp_stat                   o_stat,
    input  logic [wbig_pkg::PIXEL_W-1:0]         i_pixel_value,
    input  logic [wbig_pkg::DIM_W-1:0]           i_window_height,
    input  logic [wbig_pkg::DIM_W-1:0]           i_window_width,
    input  logic [wbig_pkg::RECIP_W-1:0]         i_border_recip,
    input  logic [wbig_pkg::RECIP_W-1:0]         i_interior_recip,
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    output logic signed [wbig_pkg::SCORE_W-1:0]  o_score
);

    localparam int PW   = $clog2(MAX_WINDOW_SIDE);
    localparam int SDW  = PW + 1;
    localparam int LOGA = $clog2(MAX_WINDOW_SIDE * MAX_WINDOW_SIDE);
    localparam int CW   = $clog2(MAX_WINDOW_SIDE * MAX_WINDOW_SIDE + 1);
    localparam int SW   = wbig_pkg::PIXEL_W + LOGA;
    localparam int QW   = 2 * wbig_pkg::PIXEL_W + LOGA;
    localparam int AW   = QW + CW;
    localparam int BW   = 2 * SW;
    localparam int NW   = AW + 8;
    localparam int SCW  = QW + 8;
    localparam int RW   = wbig_pkg::RECIP_W;
    localparam int P1W  = SCW + 1 + RW + 1;
    localparam int P2W  = SCW + RW;
    localparam int ACW  = P1W + 1;

    localparam logic signed [ACW-1:0] SAT_MAX = ACW'(wbig_pkg::SCORE_MAX);
    localparam logic signed [ACW-1:0] SAT_MIN = ACW'(wbig_pkg::SCORE_MIN);

    function automatic logic [SDW-1:0] side_used(input logic [wbig_pkg::DIM_W-1:0] v);
        logic [7:0] v8;
        v8 = 8'(v);
        if (v8 < 8'd3) begin
            return SDW'(3);
        end
        if (v8 > 8'(MAX_WINDOW_SIDE)) begin
            return SDW'(MAX_WINDOW_SIDE);
        end
        return SDW'(v8);
    endfunction

    // Window geometry and position.
    logic [SDW-1:0]   h_used, w_used;
    logic [PW-1:0]    r_row, r_col;
    logic             last_row, last_col, ring;

    // Group sums.
    logic [SW-1:0]    r_bsum, r_isum;
    logic [QW-1:0]    r_bsq, r_isq;
    logic [15:0]      pix_sq;

    // Scatter unit.
    logic [CW-1:0]    n_border, n_interior, n_whole;
    logic [2*SDW-1:0] ni_full, nw_full;
    logic [SW-1:0]    r_op_s;
    logic [QW-1:0]    r_op_sq;
    logic [CW-1:0]    r_op_n;
    logic [AW-1:0]    a_prod, r_a;
    logic [BW-1:0]    b_prod, r_b;
    logic [NW-1:0]    dividend;
    logic [NW-1:0]    quotient;
    logic             div_done;
    logic [SCW-1:0]   r_sb, r_si, r_sw, scatter_new;

    // Score.
    logic signed [SCW:0]   sdiff;
    logic signed [RW:0]    ri_s;
    logic signed [P1W-1:0] r_p1;
    logic [P2W-1:0]        r_p2;
    logic signed [ACW-1:0] acc, acc_sh;
    logic signed [wbig_pkg::SCORE_W-1:0] score_sat;
    logic                  r_out_valid;
    logic signed [wbig_pkg::SCORE_W-1:0] r_score;

    assign h_used   = side_used(i_window_height);
    assign w_used   = side_used(i_window_width);
    assign last_row = ({1'b0, r_row} >= (h_used - SDW'(1)));
    assign last_col = ({1'b0, r_col} >= (w_used - SDW'(1)));
    assign ring     = (r_row == '0) || (r_col == '0) || last_row || last_col;
    assign pix_sq   = i_pixel_value * i_pixel_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_bsum <= '0;
            r_bsq  <= '0;
            r_isum <= '0;
            r_isq  <= '0;
        end else if (i_cmd.load_out) begin
            r_bsum <= '0;
            r_bsq  <= '0;
            r_isum <= '0;
            r_isq  <= '0;
        end else if (i_cmd.acc_en) begin
            if (ring) begin
                r_bsum <= r_bsum + SW'(i_pixel_value);
                r_bsq  <= r_bsq + QW'(pix_sq);
            end else begin
                r_isum <= r_isum + SW'(i_pixel_value);
                r_isq  <= r_isq + QW'(pix_sq);
            end
            if (last_col) begin
                r_col <= '0;
                if (last_row) begin
                    r_row <= '0;
                end else begin
                    r_row <= r_row + 1'b1;
                end
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    // Pixel counts of the groups from the dimensions in force.
    assign ni_full    = (w_used - SDW'(2)) * (h_used - SDW'(2));
    assign nw_full    = w_used * h_used;
    assign n_border   = CW'({w_used, 1'b0}) + CW'({h_used, 1'b0})
                      - CW'(wbig_pkg::RING_CORNERS);
    assign n_interior = CW'(ni_full);
    assign n_whole    = CW'(nw_full);

    assign a_prod   = r_op_sq * r_op_n;
    assign b_prod   = r_op_s * r_op_s;
    assign dividend = {r_a - AW'(r_b), 8'd0};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_ops) begin
            case (i_cmd.grp)
                wbig_pkg::GRP_BORDER: begin
                    r_op_s  <= r_bsum;
                    r_op_sq <= r_bsq;
                    r_op_n  <= n_border;
                end
                wbig_pkg::GRP_INTERIOR: begin
                    r_op_s  <= r_isum;
                    r_op_sq <= r_isq;
                    r_op_n  <= n_interior;
                end
                default: begin
                    r_op_s  <= r_bsum + r_isum;
                    r_op_sq <= r_bsq + r_isq;
                    r_op_n  <= n_whole;
                end
            endcase
        end
        if (i_cmd.mul_ops) begin
            r_a <= a_prod;
            r_b <= b_prod;
        end
    end

    wbig_div #(
        .NW (NW),
        .DW (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dividend),
        .i_divisor  (r_op_n),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    assign scatter_new = i_cmd.store_quot ? SCW'(quotient) : '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.store_quot || i_cmd.store_zero) begin
            case (i_cmd.grp)
                wbig_pkg::GRP_BORDER:   r_sb <= scatter_new;
                wbig_pkg::GRP_INTERIOR: r_si <= scatter_new;
                default:                r_sw <= scatter_new;
            endcase
        end
    end

    // Score: (Sw - Si) * Ri - Sb * Rb in Q24, floored to Q8 and saturated.
    assign sdiff  = $signed({1'b0, r_sw}) - $signed({1'b0, r_si});
    assign ri_s   = $signed({1'b0, i_interior_recip});
    assign acc    = ACW'(r_p1) - $signed({{(ACW - P2W){1'b0}}, r_p2});
    assign acc_sh = acc >>> 16;

    always_comb begin
        if (acc_sh > SAT_MAX) begin
            score_sat = wbig_pkg::SCORE_MAX;
        end else if (acc_sh < SAT_MIN) begin
            score_sat = wbig_pkg::SCORE_MIN;
        end else begin
            score_sat = acc_sh[wbig_pkg::SCORE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.score_mul) begin
            r_p1 <= sdiff * ri_s;
            r_p2 <= r_sb * i_border_recip;
        end
        if (i_cmd.load_out) begin
            r_score <= score_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_score     = r_score;

    assign o_stat.last_pixel   = last_row && last_col;
    assign o_stat.not_positive = (r_a <= AW'(r_b));
    assign o_stat.div_done     = div_done;
    assign o_stat.out_free     = !r_out_valid || i_out_ready;

endmodule

>>> rtl/core/window_border_interior_glrt.sv
// Top level of the window border/interior GLRT detector: register file,
// sequencer and datapath. Depends on wbig_pkg, wbig_ctrl and wbig_dp.
`timescale 1ns / 1ps

// The block takes the pixels of one detection window in raster order, one
// beat per pixel on the input channel (i_valid, o_ready, i_pixel_value).
// A pixel is taken in a single cycle, so a window streams in at one pixel
// per clock. The window's last pixel starts a finishing phase during which
// o_ready is low: the border, interior and whole-window scatters are formed
// one after the other, each by a multiply step and a restoring divider that
// makes one quotient bit per cycle, followed by the score multiply. With the
// default MAX_WINDOW_SIDE of 32 the divider is 45 bits long; a group whose
// numerator is not positive skips the divider and its scatter is zero.
// The score then goes to an output register and leaves as one beat on the
// output channel (o_valid, i_ready, o_score). Input opens again as soon as
// the score is loaded, so the next window streams in while the score waits.
// If the receiver stalls so long that the next window ends first, the block
// holds that window's score inside until the output register is free.
// The registers are written over the APB-style port; pready is always high.
// Writes are meant for idle time; a new size takes effect at the next pixel.
// Synchronous reset returns the registers to their defaults and clears the
// position counters, the running sums and the output valid flag.
module window_border_interior_glrt #(
    parameter int MAX_WINDOW_SIDE = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Pixel input.
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [wbig_pkg::PIXEL_W-1:0]         i_pixel_value,
    // Score output.
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [wbig_pkg::SCORE_W-1:0]  o_score,
    // Register port.
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [wbig_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [wbig_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [wbig_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready
);

    logic [wbig_pkg::DIM_W-1:0]   r_window_height;
    logic [wbig_pkg::DIM_W-1:0]   r_window_width;
    logic [wbig_pkg::RECIP_W-1:0] r_border_recip;
    logic [wbig_pkg::RECIP_W-1:0] r_interior_recip;
    logic [1:0]                   reg_index;
    logic                         reg_write;

    wbig_pkg::t_dp_cmd  dp_cmd;
    wbig_pkg::t_dp_stat dp_stat;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign reg_write = psel && penable && pwrite && pready;

    // Each register keeps only its own width of the written word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_height  <= wbig_pkg::RST_WINDOW_HEIGHT;
            r_window_width   <= wbig_pkg::RST_WINDOW_WIDTH;
            r_border_recip   <= wbig_pkg::RST_RECIP;
            r_interior_recip <= wbig_pkg::RST_RECIP;
        end else if (reg_write) begin
            case (reg_index)
                wbig_pkg::REG_WINDOW_HEIGHT: begin
                    r_window_height <= pwdata[wbig_pkg::DIM_W-1:0];
                end
                wbig_pkg::REG_WINDOW_WIDTH: begin
                    r_window_width <= pwdata[wbig_pkg::DIM_W-1:0];
                end
                wbig_pkg::REG_BORDER_VARIANCE_RECIP: begin
                    r_border_recip <= pwdata[wbig_pkg::RECIP_W-1:0];
                end
                wbig_pkg::REG_INTERIOR_VARIANCE_RECIP: begin
                    r_interior_recip <= pwdata[wbig_pkg::RECIP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Reads return the stored value, zero-extended to the bus width.
    always_comb begin
        case (reg_index)
            wbig_pkg::REG_WINDOW_HEIGHT: begin
                prdata = wbig_pkg::APB_DATA_W'(r_window_height);
            end
            wbig_pkg::REG_WINDOW_WIDTH: begin
                prdata = wbig_pkg::APB_DATA_W'(r_window_width);
            end
            wbig_pkg::REG_BORDER_VARIANCE_RECIP: begin
                prdata = wbig_pkg::APB_DATA_W'(r_border_recip);
            end
            wbig_pkg::REG_INTERIOR_VARIANCE_RECIP: begin
                prdata = wbig_pkg::APB_DATA_W'(r_interior_recip);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    // The sequencer owns the input handshake and steps the finishing phase.
    wbig_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    // The datapath holds the sums, the scatter unit and the output register.
    wbig_dp #(
        .MAX_WINDOW_SIDE (MAX_WINDOW_SIDE)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .o_stat           (dp_stat),
        .i_pixel_value    (i_pixel_value),
        .i_window_height  (r_window_height),
        .i_window_width   (r_window_width),
        .i_border_recip   (r_border_recip),
        .i_interior_recip (r_interior_recip),
        .i_out_ready      (i_ready),
        .o_out_valid      (o_valid),
        .o_score          (o_score)
    );

endmodule
